// ===== sv/mor_pkg.sv =====
// Shared types, codes and constants for the overlay relocator.
// Used by every module of the block; depends on nothing.
package mor_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // Masks and fixed bits of the relocation arithmetic
   localparam logic [31:0] MASK_SKIP_BITS = 32'h0F00_0000;
   localparam logic [31:0] MASK_HI_HALF   = 32'hFFFF_0000;
   localparam logic [3:0]  JUMP_SEGMENT   = 4'h8;

   // Relocation kinds
   typedef enum logic [1:0] {
      FUNC_WORD32 = 2'd0,
      FUNC_JUMP26 = 2'd1,
      FUNC_HI16   = 2'd2,
      FUNC_LO16   = 2'd3
   } func_type;

   // Section codes
   typedef enum logic [1:0] {
      SECT_ABS    = 2'd0,
      SECT_TEXT   = 2'd1,
      SECT_DATA   = 2'd2,
      SECT_RODATA = 2'd3
   } section_type;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_LOAD_BASE = 2'd0,
      CSR_LINK_BASE = 2'd1,
      CSR_TEXT_SIZE = 2'd2,
      CSR_DATA_SIZE = 2'd3
   } csr_index_type;

   // One relocation item as held in the input register
   typedef struct packed {
      func_type    func;
      section_type section;
      logic [23:0] offset;
      logic [31:0] word;
   } req_item_type;

   // One write result
   typedef struct packed {
      logic [31:0] write_addr;
      logic [31:0] write_data;
      logic        last;
   } result_type;

   // Values derived from the configuration registers
   typedef struct packed {
      logic [31:0] load_base;
      logic [31:0] data_base;
      logic [31:0] rodata_base;
      logic [31:0] delta;
   } cfg_type;

   // HI16 table fill
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [31:0]      addr;
      logic [31:0]      word;
   } hi_wr_type;

   // Write seen by the table to keep current words equal to memory
   typedef struct packed {
      logic        en;
      logic [31:0] addr;
      logic [31:0] data;
   } track_type;

   // One table entry as read
   typedef struct packed {
      logic [31:0] tgt;
      logic [31:0] orig;
      logic [31:0] cur;
   } entry_type;

endpackage

// ===== sv/mor_cfg.sv =====
// Configuration registers and the section bases and rebase delta derived from them.
// Depends on mor_pkg.
module mor_cfg
   import mor_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   logic [31:0] load_ff, load_in;
   logic [31:0] link_ff, link_in;
   logic [23:0] text_ff, text_in;
   logic [23:0] data_ff, data_in;
   cfg_type     cfg_ff, cfg_in;

   // Decode the register write
   always_comb begin
      load_in = load_ff;
      link_in = link_ff;
      text_in = text_ff;
      data_in = data_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LOAD_BASE: load_in = csr_wdata;
            CSR_LINK_BASE: link_in = csr_wdata;
            CSR_TEXT_SIZE: text_in = csr_wdata[23:0];
            CSR_DATA_SIZE: data_in = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Derive bases from the next register values so they track the write edge
   always_comb begin
      cfg_in.load_base   = load_in;
      cfg_in.data_base   = load_in + {8'd0, text_in};
      cfg_in.rodata_base = cfg_in.data_base + {8'd0, data_in};
      cfg_in.delta       = load_in - link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         link_ff <= '0;
         text_ff <= '0;
         data_ff <= '0;
         cfg_ff  <= '0;
      end else begin
         load_ff <= load_in;
         link_ff <= link_in;
         text_ff <= text_in;
         data_ff <= data_in;
         cfg_ff  <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/mor_table.sv =====
// HI16 table: per-rt LUI address, original and current word, with write tracking.
// Depends on mor_pkg.
module mor_table
   import mor_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry,
   input  hi_wr_type        hi_wr,
   input  track_type        track0,
   input  track_type        track1
);

   logic [31:0] tgt_ff  [TABLE_DEPTH];
   logic [31:0] orig_ff [TABLE_DEPTH];
   logic [31:0] cur_ff  [TABLE_DEPTH];
   logic [31:0] tgt_in  [TABLE_DEPTH];
   logic [31:0] orig_in [TABLE_DEPTH];
   logic [31:0] cur_in  [TABLE_DEPTH];

   // Fill on HI16; otherwise follow writes in output order, the later one winning
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tgt_in[i]  = tgt_ff[i];
         orig_in[i] = orig_ff[i];
         cur_in[i]  = cur_ff[i];
         if (hi_wr.en && hi_wr.idx == IDX_W'(i)) begin
            tgt_in[i]  = hi_wr.addr;
            orig_in[i] = hi_wr.word;
            cur_in[i]  = hi_wr.word;
         end else if (track1.en && tgt_ff[i] == track1.addr) begin
            cur_in[i] = track1.data;
         end else if (track0.en && tgt_ff[i] == track0.addr) begin
            cur_in[i] = track0.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tgt_ff[i]  <= tgt_in[i];
         orig_ff[i] <= orig_in[i];
         cur_ff[i]  <= cur_in[i];
      end
   end

   // Read the entry named by the LO16 rs field
   assign rd_entry.tgt  = tgt_ff[rd_idx];
   assign rd_entry.orig = orig_ff[rd_idx];
   assign rd_entry.cur  = cur_ff[rd_idx];

endmodule

// ===== sv/mor_calc.sv =====
// Relocation arithmetic for the item in the input register: results, count, table fill.
// Depends on mor_pkg.
module mor_calc
   import mor_pkg::*;
(
   input  req_item_type     item,
   input  cfg_type          cfg,
   input  entry_type        entry,
   output logic [IDX_W-1:0] rd_idx,
   output logic [1:0]       need,
   output result_type       res0,
   output result_type       res1,
   output hi_wr_type        hi_wr
);

   logic [31:0] sect_base;
   logic [31:0] addr;
   logic [31:0] jump_tgt;
   logic [31:0] jump_new;
   logic [31:0] lo_ext;
   logic [31:0] lo_check;
   logic [31:0] lo_sum;
   logic [16:0] hi_carry;

   // Select the section base and form the target address
   always_comb begin
      case (item.section)
         SECT_ABS:    sect_base = '0;
         SECT_TEXT:   sect_base = cfg.load_base;
         SECT_DATA:   sect_base = cfg.data_base;
         SECT_RODATA: sect_base = cfg.rodata_base;
         default:     sect_base = '0;
      endcase
   end

   assign addr = sect_base + {8'd0, item.offset};

   // Jump target rebased within its segment
   assign jump_tgt = {JUMP_SEGMENT, item.word[25:0], 2'b00} + cfg.delta;

   // Hi/lo pair: validity on the current word, rebase on the original word
   assign lo_ext   = {{16{item.word[15]}}, item.word[15:0]};
   assign rd_idx   = item.word[25:21];
   assign lo_check = {entry.cur[15:0], 16'd0} + lo_ext;
   assign lo_sum   = {entry.orig[15:0], 16'd0} + lo_ext + cfg.delta;
   assign hi_carry = {1'b0, lo_sum[31:16]} + {16'd0, lo_sum[15]};

   always_comb begin
      need      = 2'd0;
      res0      = '0;
      res1      = '0;
      hi_wr     = '0;
      jump_new  = {item.word[31:26], jump_tgt[27:2]};
      case (item.func)
         FUNC_WORD32: begin
            if ((item.word & MASK_SKIP_BITS) == '0) begin
               need = 2'd1;
            end
            res0.write_addr = addr;
            res0.write_data = item.word + cfg.delta;
            res0.last       = 1'b1;
         end
         FUNC_JUMP26: begin
            need            = 2'd1;
            res0.write_addr = addr;
            res0.write_data = jump_new;
            res0.last       = 1'b1;
         end
         FUNC_HI16: begin
            hi_wr.en   = 1'b1;
            hi_wr.idx  = item.word[20:16];
            hi_wr.addr = addr;
            hi_wr.word = item.word;
         end
         FUNC_LO16: begin
            if ((lo_check & MASK_SKIP_BITS) == '0) begin
               need = 2'd2;
            end
            res0.write_addr = entry.tgt;
            res0.write_data = (entry.cur & MASK_HI_HALF) | {15'd0, hi_carry};
            res0.last       = 1'b0;
            res1.write_addr = addr;
            res1.write_data = {item.word[31:16], lo_sum[15:0]};
            res1.last       = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/mor_outq.sv =====
// Two-entry result queue that takes up to two results at once and hands out one a cycle when popped.
// Depends on mor_pkg.
module mor_outq
   import mor_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_cnt,
   input  result_type push0,
   input  result_type push1,
   input  logic       pop,
   output logic       head_valid,
   output result_type head,
   output logic [1:0] free
);

   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   result_type rem0;
   logic [1:0] rem_cnt;

   // Drop the head on pop, then append new results behind what remains
   always_comb begin
      rem0    = slot0_ff;
      rem_cnt = count_ff;
      if (pop) begin
         rem0    = slot1_ff;
         rem_cnt = count_ff - 2'd1;
      end
      slot0_in = rem0;
      slot1_in = slot1_ff;
      case (push_cnt)
         2'd1: begin
            if (rem_cnt == 2'd0) begin
               slot0_in = push0;
            end else begin
               slot1_in = push0;
            end
         end
         2'd2: begin
            slot0_in = push0;
            slot1_in = push1;
         end
         default: ;
      endcase
      count_in = rem_cnt + push_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign head_valid = (count_ff != 2'd0);
   assign head       = slot0_ff;
   assign free       = (2'd2 - count_ff) + {1'b0, pop};

endmodule

// ===== sv/mips_overlay_relocator.sv =====
// Overlay relocator top level: input register, relocation arithmetic, HI16 table, result queue.
// Depends on mor_pkg, mor_cfg, mor_table, mor_calc and mor_outq.
//
//   channel  ports                                   direction  moves
//   req      req_valid/req_stall, func..word         in         one relocation item
//   rsp      rsp_valid/rsp_stall, write_addr..last   out        one write result
//   csr      csr_we, csr_index, csr_wdata            in         one register write
//
// An item enters the input register, and its results are queued as it leaves it.
// WORD32 and JUMP26 sustain one item a cycle while rsp is not stalled; LO16 is held
// back by the single result port draining its two writes; HI16 gives no result.
// Reset is synchronous and empties the input register and the result queue; the
// HI16 table is not cleared. A stalled rsp backs up into req_stall once the queue lacks room.
module mips_overlay_relocator
   import mor_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_section,
   input  logic [23:0] req_offset,
   input  logic [31:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_write_addr,
   output logic [31:0] rsp_write_data,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic             s1_valid_ff, s1_valid_in;
   req_item_type     s1_item_ff;
   cfg_type          cfg;
   entry_type        entry;
   logic [IDX_W-1:0] rd_idx;
   logic [1:0]       need;
   result_type       res0, res1;
   hi_wr_type        hi_calc, hi_wr;
   track_type        track0, track1;
   logic [1:0]       free;
   logic             advance;
   logic             accept;
   logic             pop;
   result_type       head;

   mor_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mor_calc u_calc (
      .item   (s1_item_ff),
      .cfg    (cfg),
      .entry  (entry),
      .rd_idx (rd_idx),
      .need   (need),
      .res0   (res0),
      .res1   (res1),
      .hi_wr  (hi_calc)
   );

   // Hand the item on once the queue has room for all its results
   assign advance   = s1_valid_ff && (need <= free);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   // Table updates only for an item that leaves the input register
   always_comb begin
      hi_wr       = hi_calc;
      hi_wr.en    = hi_calc.en && advance;
      track0.en   = advance && (need != 2'd0);
      track0.addr = res0.write_addr;
      track0.data = res0.write_data;
      track1.en   = advance && (need == 2'd2);
      track1.addr = res1.write_addr;
      track1.data = res1.write_data;
   end

   mor_table u_table (
      .clock    (clock),
      .rd_idx   (rd_idx),
      .rd_entry (entry),
      .hi_wr    (hi_wr),
      .track0   (track0),
      .track1   (track1)
   );

   mor_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (advance ? need : 2'd0),
      .push0      (res0),
      .push1      (res1),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head       (head),
      .free       (free)
   );

   // Load or empty the input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.func    <= func_type'(req_func);
         s1_item_ff.section <= section_type'(req_section);
         s1_item_ff.offset  <= req_offset;
         s1_item_ff.word    <= req_word;
      end
   end

   assign rsp_write_addr = head.write_addr;
   assign rsp_write_data = head.write_data;
   assign rsp_last       = head.last;

`ifndef SYNTHESIS
   // A LO16 pair enters an empty queue, so the LUI write shows first
   a_lo16_order: assert property (@(posedge clock) disable iff (reset)
      (advance && need == 2'd2) |=> (rsp_valid && !rsp_last))
      else $error("LO16 pair not led by its LUI write");

   // HI16 never waits for queue room
   a_hi16_flows: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_item_ff.func == FUNC_HI16) |-> advance)
      else $error("HI16 item held in input register");

   // An empty input register never stalls the request side
   a_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("request stalled with empty input register");
`endif

endmodule
